@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file qtp_checker.sv
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qtp assertion failed");

// antecedent implies consequent in the next cycle
`define QTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qtp assertion failed");

`endif

@@ rtl/qtp_pkg.sv @@
// shared types and constants of the quantized tanh activation
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qtp_pkg;

  localparam int unsigned DATA_FRAC_DEF = 24;
  localparam int unsigned X_W           = 32;
  localparam int unsigned Y_W           = 26;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned FB_W          = 5;

  localparam logic [FB_W-1:0] FRAC_BITS_RST = 5'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUANT_ENABLE = 2'd0,
    REG_FRAC_BITS    = 2'd1,
    REG_ROUND_MODE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic            quant_enable;
    logic [FB_W-1:0] frac_bits;
    logic            round_mode;
  } cfg_t;

  typedef struct packed {
    logic neg;
    logic big;
  } flags_t;

endpackage

`default_nettype wire

@@ rtl/qtp_if.sv @@
// valid/ready channel interfaces: config writes, input samples, results
// depends on qtp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface qtp_cfg_if import qtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

interface qtp_in_if import qtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;
  modport source (output valid, x_value, input ready);
  modport sink   (input valid, x_value, output ready);
endinterface

interface qtp_out_if import qtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [Y_W-1:0] y_value;
  modport source (output valid, y_value, input ready);
  modport sink   (input valid, y_value, output ready);
endinterface

`default_nettype wire

@@ rtl/quantized_tanh_poly_activation.sv @@
// quartic polynomial tanh on fixed-point samples, ten-stage pipeline
// depends on qtp_pkg and the channel interfaces in qtp_if.sv
//
//   channel  | dir | payload               | notes
//   cfg_i    | in  | index, wdata          | always ready, one register per transaction
//   in_i     | in  | x_value (s32, Q.F)    | ready is a registered signal
//   out_o    | out | y_value (s26, Q.F)    | one result per input transaction
//
// one sample per cycle while in_i.ready is high; a result is offered when its sample
// has passed through all the register stages; the 51x51 square-difference product
// (DATA_FRAC 24) is split into four partial products of at most 26x26 over two stages
// reset clears valid bits and the configuration registers
// a one-entry skid register behind the last stage holds a result while out_o stalls;
// in_i.ready drops only while that register is full
`timescale 1ns / 1ps
`default_nettype none

module quantized_tanh_poly_activation import qtp_pkg::*; #(
  parameter int unsigned DATA_FRAC = DATA_FRAC_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qtp_cfg_if.sink    cfg_i,
  qtp_in_if.sink     in_i,
  qtp_out_if.source  out_o
);

  localparam int unsigned F    = DATA_FRAC;
  localparam int unsigned AW   = F + 1;
  localparam int unsigned SQW  = 2 * AW;
  localparam int unsigned SW   = 2 * F + 3;
  localparam int unsigned HW   = (SW + 1) / 2;
  localparam int unsigned HIW  = SW - HW;
  localparam int unsigned PPW  = 2 * HW;
  localparam int unsigned PW   = 2 * SW;
  localparam int unsigned VW   = 4 * F + 7;
  localparam int unsigned ShW  = $clog2(VW);
  localparam int unsigned VSW  = F + 3;
  localparam int unsigned MW   = F + 1;
  localparam int unsigned YEW  = (F + 2 > Y_W) ? F + 2 : Y_W;
  localparam int unsigned NST  = 10;

  localparam logic [X_W-1:0] TwoF = X_W'(2) << F;

  // configuration
  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_QUANT_ENABLE: cfg_d.quant_enable = cfg_i.wdata[0];
        REG_FRAC_BITS:    cfg_d.frac_bits    = cfg_i.wdata[FB_W-1:0];
        REG_ROUND_MODE:   cfg_d.round_mode   = cfg_i.wdata[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{quant_enable: 1'b0, frac_bits: FRAC_BITS_RST, round_mode: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // effective fraction bits, clamped to the output precision
  logic [FB_W-1:0] q_eff;
  assign q_eff = (cfg_q.frac_bits > FB_W'(F)) ? FB_W'(F) : cfg_q.frac_bits;

  // pipeline control
  logic           en;
  logic           skid_vld_q, skid_vld_d;
  logic [Y_W-1:0] skid_y_q;
  logic [NST-1:0] vld_q;
  logic           in_acc;

  assign en         = !skid_vld_q;
  assign in_i.ready = en;
  assign in_acc     = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_acc};
    end
  end

  // stage registers
  logic [X_W-1:0]  x1_q;
  flags_t          fl_q [2:NST-1];
  logic [AW-1:0]   a_q  [2:7];
  logic [SQW-1:0]  s3_q;
  logic [SW-1:0]   s4_q, s5_q, d5_q;
  logic            ge_q [5:7];
  logic [PPW-1:0]  pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [PW-1:0]   prod7_q;
  logic [VW-1:0]   val8_q;
  logic [VSW-1:0]  v9_q;
  logic [FB_W-1:0] p9_q;
  logic [Y_W-1:0]  y10_q;

  // stage 2: magnitude and range flag
  logic [X_W-1:0] a_full;
  flags_t         fl2_d;
  assign a_full    = x1_q[X_W-1] ? (~x1_q + X_W'(1)) : x1_q;
  assign fl2_d.neg = x1_q[X_W-1];
  assign fl2_d.big = a_full >= TwoF;

  // stage 3: square
  logic [SQW-1:0] s3_d;
  assign s3_d = SQW'(a_q[2]) * SQW'(a_q[2]);

  // stage 4: quantize the square when quantization is enabled
  logic [ShW-1:0] r_sh;
  logic [SW-1:0]  s_radd, s_sum, s4_d;
  always_comb begin
    r_sh   = cfg_q.quant_enable ? (ShW'(2 * F) - ShW'(q_eff)) : '0;
    s_radd = (cfg_q.quant_enable && cfg_q.round_mode && r_sh != '0)
             ? (SW'(1) << (r_sh - ShW'(1))) : '0;
    s_sum  = SW'(s3_q) + s_radd;
    s4_d   = s_sum & ({SW{1'b1}} << r_sh);
  end

  // stage 5: difference between 4a and s
  logic [SW-1:0] four_a, d5_d;
  logic          ge5_d;
  always_comb begin
    four_a = SW'(a_q[4]) << (F + 2);
    ge5_d  = four_a >= s4_q;
    d5_d   = ge5_d ? (four_a - s4_q) : (s4_q - four_a);
  end

  // stage 6: partial products of s * d
  logic [HW-1:0]  s_lo, d_lo;
  logic [HIW-1:0] s_hi, d_hi;
  logic [PPW-1:0] pp_ll_d, pp_lh_d, pp_hl_d, pp_hh_d;
  always_comb begin
    s_lo    = s5_q[HW-1:0];
    s_hi    = s5_q[SW-1:HW];
    d_lo    = d5_q[HW-1:0];
    d_hi    = d5_q[SW-1:HW];
    pp_ll_d = PPW'(s_lo) * PPW'(d_lo);
    pp_lh_d = PPW'(s_lo) * PPW'(d_hi);
    pp_hl_d = PPW'(s_hi) * PPW'(d_lo);
    pp_hh_d = PPW'(s_hi) * PPW'(d_hi);
  end

  // stage 7: combine partial products
  logic [PW-1:0] prod7_d;
  assign prod7_d = PW'(pp_ll_q) + (PW'(pp_lh_q) << HW) + (PW'(pp_hl_q) << HW)
                 + (PW'(pp_hh_q) << (2 * HW));

  // stage 8: a*2^(3F+4) -/+ s*|4a - s|, floored at zero
  logic [VW-1:0] big_a, prod_v, val8_d;
  always_comb begin
    big_a  = VW'(a_q[7]) << (3 * F + 4);
    prod_v = VW'(prod7_q);
    if (ge_q[7]) begin
      val8_d = (prod_v > big_a) ? '0 : (big_a - prod_v);
    end else begin
      val8_d = big_a + prod_v;
    end
  end

  // stage 9: scale down to p fraction bits, rounding in quantized round mode
  logic [FB_W-1:0] p9_d;
  logic [ShW-1:0]  sh9;
  logic [VW-1:0]   v_radd, v_sum, v_shr;
  logic [VSW-1:0]  v9_d;
  always_comb begin
    p9_d   = cfg_q.quant_enable ? q_eff : FB_W'(F);
    sh9    = ShW'(4 * F + 4) - ShW'(p9_d);
    v_radd = (cfg_q.quant_enable && cfg_q.round_mode) ? (VW'(1) << (sh9 - ShW'(1))) : '0;
    v_sum  = val8_q + v_radd;
    v_shr  = v_sum >> sh9;
    v9_d   = v_shr[VSW-1:0];
  end

  // stage 10: clamp to one, force one for big inputs, rescale, apply sign
  logic [VSW-1:0] one_p, v_cl;
  logic [MW-1:0]  mag;
  logic [YEW-1:0] mag_e, y_full;
  logic [Y_W-1:0] y10_d;
  always_comb begin
    one_p  = VSW'(1) << p9_q;
    v_cl   = (v9_q > one_p) ? one_p : v9_q;
    mag    = fl_q[9].big ? (MW'(1) << F) : (MW'(v_cl) << (FB_W'(F) - p9_q));
    mag_e  = YEW'(mag);
    y_full = fl_q[9].neg ? (~mag_e + YEW'(1)) : mag_e;
    y10_d  = y_full[Y_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= in_i.x_value;
      fl_q[2] <= fl2_d;
      for (int i = 3; i < NST; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
      a_q[2]  <= a_full[AW-1:0];
      for (int i = 3; i <= 7; i++) begin
        a_q[i] <= a_q[i-1];
      end
      s3_q    <= s3_d;
      s4_q    <= s4_d;
      s5_q    <= s4_q;
      d5_q    <= d5_d;
      ge_q[5] <= ge5_d;
      ge_q[6] <= ge_q[5];
      ge_q[7] <= ge_q[6];
      pp_ll_q <= pp_ll_d;
      pp_lh_q <= pp_lh_d;
      pp_hl_q <= pp_hl_d;
      pp_hh_q <= pp_hh_d;
      prod7_q <= prod7_d;
      val8_q  <= val8_d;
      v9_q    <= v9_d;
      p9_q    <= p9_d;
      y10_q   <= y10_d;
    end
  end

  // skid register behind the last stage
  always_comb begin
    if (en) begin
      skid_vld_d = vld_q[NST-1] && !out_o.ready;
    end else begin
      skid_vld_d = !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skid_y_q <= y10_q;
    end
  end

  assign out_o.valid   = skid_vld_q || vld_q[NST-1];
  assign out_o.y_value = skid_vld_q ? skid_y_q : y10_q;

endmodule

`default_nettype wire

@@ rtl/qtp_checker.sv @@
// port-level checks on the quantized tanh activation, bound to the top level
// depends on qtp_pkg, assert_macros.svh and quantized_tanh_poly_activation
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qtp_checker import qtp_pkg::*; #(
  parameter int unsigned DATA_FRAC = DATA_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic signed [Y_W-1:0] out_y_i
);

  localparam logic signed [Y_W-1:0] YMax = Y_W'(1) << 24;
  localparam logic signed [Y_W-1:0] YMin = -YMax;
  localparam logic                  WideFrac = DATA_FRAC > 24;

  // a stalled result stays offered
  `QTP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // and keeps its value
  `QTP_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_y_i))
  // input backpressure only while a result waits at the output
  `QTP_ASSERT_IMP(a_bp_cause, clk_i, rst_ni, !in_ready_i, out_valid_i)
  // results stay within +-2^24 (-1..1 at DATA_FRAC 24); not checked for DATA_FRAC above 24
  `QTP_ASSERT_IMP(a_y_range, clk_i, rst_ni, out_valid_i && in_valid_i || out_valid_i, WideFrac || (out_y_i <= YMax && out_y_i >= YMin))

endmodule

bind quantized_tanh_poly_activation qtp_checker #(
  .DATA_FRAC (DATA_FRAC)
) u_qtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_y_i     (out_o.y_value)
);

`default_nettype wire

@@ test/quantized_tanh_poly_activation_check.sv @@
// result checker for the quantized tanh activation: tracks config writes, predicts
// each result from the accepted sample and compares it with the out channel
// depends on qtp_pkg and the channel interfaces in qtp_if.sv
`timescale 1ns / 1ps

module quantized_tanh_poly_activation_check import qtp_pkg::*; #(
  parameter int unsigned DATA_FRAC = DATA_FRAC_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qtp_cfg_if          cfg_mon,
  qtp_in_if           in_mon,
  qtp_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  cfg_t           tanh_cfg;
  logic [Y_W-1:0] tanh_expected_q[$];

  // quartic tanh: y = s*(s/16 - a/4) + a below magnitude two, else one
  // all terms are kept at 4*F+4 fraction bits before the final cut
  function automatic logic [Y_W-1:0] tanh_quartic(logic [X_W-1:0] x, cfg_t cfg);
    logic         neg;
    logic         quant;
    logic         rnd;
    logic [63:0]  mag;
    logic [63:0]  sq;
    logic [63:0]  four_mag;
    logic [63:0]  y_mag;
    logic [63:0]  v;
    logic [127:0] big_mag;
    logic [127:0] acc;
    logic [127:0] prod;
    int unsigned  q;
    int unsigned  p;
    int unsigned  sh;
    int unsigned  r;
    neg   = x[X_W-1];
    mag   = neg ? ((64'd1 << X_W) - 64'(x)) : 64'(x);
    quant = cfg.quant_enable;
    rnd   = cfg.round_mode;
    q     = (cfg.frac_bits > DATA_FRAC) ? DATA_FRAC : cfg.frac_bits;
    if (mag >= (64'd2 << DATA_FRAC)) begin
      y_mag = 64'd1 << DATA_FRAC;
    end else begin
      sq       = mag * mag;
      four_mag = mag << (DATA_FRAC + 2);
      big_mag  = 128'(mag) << (3 * DATA_FRAC + 4);
      p        = quant ? q : DATA_FRAC;
      sh       = 4 * DATA_FRAC + 4 - p;
      if (quant) begin
        r = 2 * DATA_FRAC - q;
        if (rnd) sq = sq + (64'd1 << (r - 1));
        sq = (sq >> r) << r;
      end
      if (four_mag >= sq) begin
        prod = 128'(sq) * 128'(four_mag - sq);
        acc  = (big_mag < prod) ? '0 : big_mag - prod;
      end else begin
        acc = big_mag + 128'(sq) * 128'(sq - four_mag);
      end
      if (quant && rnd) acc = acc + (128'd1 << (sh - 1));
      acc = acc >> sh;
      v   = (acc[127:64] != '0) ? (64'd1 << p) : acc[63:0];
      // coarse quantization can push the magnitude past one
      if (v > (64'd1 << p)) v = 64'd1 << p;
      y_mag = v << (DATA_FRAC - p);
    end
    return neg ? Y_W'(64'd0 - y_mag) : Y_W'(y_mag);
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [Y_W-1:0] want;
    if (!rst_ni) begin
      tanh_cfg.quant_enable = 1'b0;
      tanh_cfg.frac_bits    = FRAC_BITS_RST;
      tanh_cfg.round_mode   = 1'b0;
      tanh_expected_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_QUANT_ENABLE: tanh_cfg.quant_enable = cfg_mon.wdata[0];
          REG_FRAC_BITS:    tanh_cfg.frac_bits    = cfg_mon.wdata[FB_W-1:0];
          REG_ROUND_MODE:   tanh_cfg.round_mode   = cfg_mon.wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        tanh_expected_q.push_back(tanh_quartic(in_mon.x_value, tanh_cfg));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (tanh_expected_q.size() == 0) begin
          fail_count_o++;
          $error("y_value unexpected transaction: expected none, actual %h",
                 out_mon.y_value);
        end else begin
          want = tanh_expected_q.pop_front();
          if (out_mon.y_value !== want) begin
            fail_count_o++;
            $error("y_value mismatch: expected %h, actual %h", want, out_mon.y_value);
          end
        end
      end
    end
    pending_o = tanh_expected_q.size();
  end

endmodule

@@ test/quantized_tanh_poly_activation_test.sv @@
// top of the quantized tanh activation test: clock, reset, config writes, samples
// and random backpressure; the verdict comes from the checker's failure and pending counts
// depends on qtp_pkg, qtp_if.sv, the block and quantized_tanh_poly_activation_check
`timescale 1ns / 1ps

module quantized_tanh_poly_activation_test;
  import qtp_pkg::*;

  localparam int unsigned DATA_FRAC = DATA_FRAC_DEF;
  localparam int unsigned LATENCY   = 10;
  localparam int unsigned PHASES    = 7;
  localparam int unsigned CHUNK     = 55;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [X_W-1:0] TWO = 32'd2 << DATA_FRAC;
  localparam logic [X_W-1:0] ONE = 32'd1 << DATA_FRAC;

  localparam logic [X_W-1:0] CORNER_SAMPLES [18] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    TWO - 32'd1, TWO, -TWO, -(TWO - 32'd1), ONE, -ONE, ONE >> 1, -(ONE >> 1),
    ONE + (ONE >> 1), ONE - 32'd1, 32'h0000_0100, 32'hFFFF_FF00
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;

  qtp_cfg_if cfg_ch ();
  qtp_in_if  in_ch ();
  qtp_out_if out_ch ();

  quantized_tanh_poly_activation #(
    .DATA_FRAC(DATA_FRAC)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  quantized_tanh_poly_activation_check #(
    .DATA_FRAC(DATA_FRAC)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_mon     (cfg_ch),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // all tasks enter and leave at a falling edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.wdata = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // upper data bits are noise, the block keeps only the field width
  task automatic apply_quant_setting(logic qe, logic [FB_W-1:0] fb, logic rm);
    write_reg(REG_QUANT_ENABLE, ($urandom() & ~32'h1) | 32'(qe));
    write_reg(REG_FRAC_BITS, ($urandom() & ~32'h1F) | 32'(fb));
    write_reg(REG_ROUND_MODE, ($urandom() & ~32'h1) | 32'(rm));
  endtask

  task automatic send_sample(logic [X_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.x_value = x;
    in_ch.valid   = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // most samples land below magnitude two where the polynomial is live
  function automatic logic [X_W-1:0] random_sample();
    logic [X_W-1:0] mag;
    int unsigned    pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return $urandom();
    end else if (pick < 25) begin
      mag = TWO - 32'd3 + $urandom_range(5);
    end else if (pick < 35) begin
      mag = $urandom_range(4096);
    end else begin
      mag = $urandom_range(TWO - 32'd1);
    end
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin
    int unsigned send_modes [4];
    int unsigned recv_modes [4];
    send_modes    = '{0, 68, 0, 32};
    recv_modes    = '{0, 0, 68, 32};
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_QUANT_ENABLE;
    cfg_ch.wdata  = '0;
    in_ch.valid   = 1'b0;
    in_ch.x_value = '0;
    rst_ni        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // phase 0 runs on reset values
    for (int unsigned k = 0; k < PHASES; k++) begin
      wait_drain();
      case (k)
        1: apply_quant_setting(1'b1, 5'd24, 1'b0);
        2: apply_quant_setting(1'b1, 5'd0, 1'b1);
        3: begin
          apply_quant_setting(1'b1, 5'd31, 1'b0);
          write_reg(REG_UNUSED, $urandom());
        end
        4: apply_quant_setting(1'b1, 5'($urandom_range(1, 23)), 1'b1);
        5: apply_quant_setting(1'b0, 5'd5, 1'b1);
        6: apply_quant_setting(1'b1, 5'($urandom_range(1, 23)), 1'b0);
        default: ;
      endcase
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i]);
      for (int unsigned m = 0; m < 4; m++) begin
        send_idle_pct  = send_modes[m];
        recv_stall_pct = recv_modes[m];
        // fill the pipeline and skid buffer so the input stalls
        if (k == 1 && m == 0) hold_request = 400;
        repeat (CHUNK) send_sample(random_sample());
      end
    end

    wait_drain();
    repeat (2 * LATENCY) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
